[rtl/etps_pkg.sv]
`default_nettype none
package etps_pkg;

    localparam int NUM_EVENTS_DEF  = 64;
    localparam int STAMP_WIDTH_DEF = 32;
    localparam int TOTAL_WIDTH_DEF = 48;

    localparam int MAX_OUT    = 64;
    localparam int OUT_CNT_W  = $clog2(MAX_OUT + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [15:0] TRACE_RESET = 16'd2000;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2,
        OP_REPORT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_TRACE = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_TRACE,
        S_SUM_RD,
        S_SUM_ACC,
        S_SI,
        S_SI2,
        S_SI3,
        S_SJ,
        S_SJ2,
        S_SJ3,
        S_SIEND,
        S_EMPTY,
        S_EM,
        S_EM2,
        S_EM3
    } state_t;

endpackage
`default_nettype wire

[rtl/etps_if.sv]
`default_nettype none
interface etps_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [5:0] event_id;
    logic [31:0] timestamp;

    modport source (output valid, operation, event_id, timestamp, input ready);
    modport sink (input valid, operation, event_id, timestamp, output ready);
endinterface

interface etps_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [5:0]  event_id_res;
    logic [47:0] time_value;
    logic [31:0] event_count;
    logic [47:0] total_sum;
    logic        last;

    modport source (output valid, kind, event_id_res, time_value, event_count,
                    total_sum, last, input ready);
    modport sink (input valid, kind, event_id_res, time_value, event_count,
                  total_sum, last, output ready);
endinterface
`default_nettype wire

[rtl/event_time_profiler_sorted.sv]
`default_nettype none
// Per-event time profiler with a sorted report.
// in_ch carries one operation per beat: clear, start, stop or report, with an
// event id and a tick stamp. out_ch carries trace records (from stops on ids
// selected in trace_mask while budget remains), report entries in descending
// total order, or a single empty marker; last marks the end of a report run.
// The cfg port (cfg_we, cfg_index, cfg_data) writes profile_enable, trace_mask
// and trace_limit; write it only while the block is idle.
// Operations: clear is handled in the idle state and in_ch stays ready. Start
// and stop read the table RAMs, then update them in S_UPD. A traced stop then
// passes through S_TRACE to hand the record to the output register.
// Report runs a sequencer: a sum pass, then an exchange sort, then emission,
// which holds while out_ch is stalled.
// Reset: configuration takes its reset values, the budget loads 2000 and every
// table entry reads as zero through its valid bit; clear drops every valid bit
// together, so no clearing pass is needed.
// Stall: results sit in an output register; when out_ch is not ready the
// sequencer holds at the step that wants to emit, and in_ch stays low until
// the current item is finished.
module event_time_profiler_sorted
    import etps_pkg::*;
#(
    parameter int NUM_EVENTS  = NUM_EVENTS_DEF,
    parameter int STAMP_WIDTH = STAMP_WIDTH_DEF,
    parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    etps_in_if.sink                    in_ch,
    etps_out_if.source                 out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IW  = $clog2(NUM_EVENTS);
    localparam int CW  = $clog2(NUM_EVENTS + 1);
    localparam int AW  = ((STAMP_WIDTH > TOTAL_WIDTH) ? STAMP_WIDTH : TOTAL_WIDTH) + 1;
    localparam int TW1 = TOTAL_WIDTH + 1;
    localparam logic [CW-1:0] LAST_IDX = CW'(NUM_EVENTS - 1);

    // Table RAMs and the sort order RAM
    logic [STAMP_WIDTH-1:0] stamp_mem [NUM_EVENTS];
    logic [TOTAL_WIDTH-1:0] total_mem [NUM_EVENTS];
    logic [31:0]            count_mem [NUM_EVENTS];
    logic [IW-1:0]          order_mem [NUM_EVENTS];

    state_t                 state_reg, state_next;
    logic                   enable_reg, enable_next;
    logic [63:0]            mask_reg, mask_next;
    logic [15:0]            limit_reg, limit_next;
    logic [15:0]            budget_reg, budget_next;
    logic [NUM_EVENTS-1:0]  valid_reg, valid_next;
    op_t                    op_reg, op_next;
    logic [IW-1:0]          id_reg, id_next;
    logic [STAMP_WIDTH-1:0] ts_reg, ts_next;
    logic [CW-1:0]          i_reg, i_next;
    logic [CW-1:0]          j_reg, j_next;
    logic [IW-1:0]          cur_id_reg, cur_id_next;
    logic [TOTAL_WIDTH-1:0] cur_tot_reg, cur_tot_next;
    logic [IW-1:0]          jid_reg, jid_next;
    logic [TOTAL_WIDTH-1:0] sum_reg, sum_next;
    logic [CW-1:0]          nz_reg, nz_next;
    logic [OUT_CNT_W-1:0]   n_reg, n_next;
    logic [47:0]            trc_el_reg, trc_el_next;
    logic [31:0]            trc_cnt_reg, trc_cnt_next;

    logic                   out_vld_reg, out_vld_next;
    logic [1:0]             out_kind_reg, out_kind_next;
    logic [5:0]             out_id_reg, out_id_next;
    logic [47:0]            out_tv_reg, out_tv_next;
    logic [31:0]            out_cnt_reg, out_cnt_next;
    logic [47:0]            out_sum_reg, out_sum_next;
    logic                   out_last_reg, out_last_next;

    // RAM ports
    logic [IW-1:0]          rd_addr;
    logic                   tab_we;
    logic [STAMP_WIDTH-1:0] wr_stamp;
    logic [TOTAL_WIDTH-1:0] wr_total;
    logic [31:0]            wr_count;
    logic [STAMP_WIDTH-1:0] stamp_q;
    logic [TOTAL_WIDTH-1:0] tot_q;
    logic [31:0]            cnt_q;
    logic                   vld_q;
    logic                   ord_we;
    logic [IW-1:0]          ord_waddr, ord_wdata, ord_raddr, ord_q;

    // Shared arithmetic
    logic [STAMP_WIDTH-1:0] stamp_e;
    logic [TOTAL_WIDTH-1:0] tot_e;
    logic [31:0]            cnt_e;
    logic [STAMP_WIDTH-1:0] elapsed;
    logic [AW-1:0]          acc_sum;
    logic [TOTAL_WIDTH-1:0] tot_new;
    logic [31:0]            cnt_new;
    logic [TW1-1:0]         rep_sum;
    logic [TOTAL_WIDTH-1:0] rep_sum_sat;
    logic [CW-1:0]          emit_lim;
    logic                   emit_last;
    logic [5:0]             id6;
    logic                   out_free;

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            stamp_mem[id_reg] <= wr_stamp;
            total_mem[id_reg] <= wr_total;
            count_mem[id_reg] <= wr_count;
        end
        stamp_q <= stamp_mem[rd_addr];
        tot_q   <= total_mem[rd_addr];
        cnt_q   <= count_mem[rd_addr];
        vld_q   <= valid_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            order_mem[ord_waddr] <= ord_wdata;
        end
        ord_q <= order_mem[ord_raddr];
    end

    // An entry not written since clear reads as zero
    assign stamp_e = vld_q ? stamp_q : '0;
    assign tot_e   = vld_q ? tot_q : '0;
    assign cnt_e   = vld_q ? cnt_q : '0;

    assign elapsed = ts_reg - stamp_e;
    assign acc_sum = AW'(tot_e) + AW'(elapsed);
    assign tot_new = (acc_sum[AW-1:TOTAL_WIDTH] != '0) ? '1 : acc_sum[TOTAL_WIDTH-1:0];
    assign cnt_new = (cnt_e == '1) ? cnt_e : cnt_e + 32'd1;

    assign rep_sum     = TW1'(sum_reg) + TW1'(tot_e);
    assign rep_sum_sat = rep_sum[TOTAL_WIDTH] ? '1 : rep_sum[TOTAL_WIDTH-1:0];

    assign emit_lim  = (int'(nz_reg) > MAX_OUT) ? CW'(MAX_OUT) : nz_reg;
    assign emit_last = ((int'(n_reg) + 1) == int'(emit_lim));

    assign id6      = 6'(id_reg);
    assign out_free = !out_vld_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            enable_reg  <= 1'b1;
            mask_reg    <= '0;
            limit_reg   <= TRACE_RESET;
            budget_reg  <= TRACE_RESET;
            valid_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            enable_reg  <= enable_next;
            mask_reg    <= mask_next;
            limit_reg   <= limit_next;
            budget_reg  <= budget_next;
            valid_reg   <= valid_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        ts_reg       <= ts_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        cur_id_reg   <= cur_id_next;
        cur_tot_reg  <= cur_tot_next;
        jid_reg      <= jid_next;
        sum_reg      <= sum_next;
        nz_reg       <= nz_next;
        n_reg        <= n_next;
        trc_el_reg   <= trc_el_next;
        trc_cnt_reg  <= trc_cnt_next;
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_tv_reg   <= out_tv_next;
        out_cnt_reg  <= out_cnt_next;
        out_sum_reg  <= out_sum_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        enable_next  = enable_reg;
        mask_next    = mask_reg;
        limit_next   = limit_reg;
        budget_next  = budget_reg;
        valid_next   = valid_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        ts_next      = ts_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        cur_id_next  = cur_id_reg;
        cur_tot_next = cur_tot_reg;
        jid_next     = jid_reg;
        sum_next     = sum_reg;
        nz_next      = nz_reg;
        n_next       = n_reg;
        trc_el_next  = trc_el_reg;
        trc_cnt_next = trc_cnt_reg;

        out_vld_next  = out_ch.ready ? 1'b0 : out_vld_reg;
        out_kind_next = out_kind_reg;
        out_id_next   = out_id_reg;
        out_tv_next   = out_tv_reg;
        out_cnt_next  = out_cnt_reg;
        out_sum_next  = out_sum_reg;
        out_last_next = out_last_reg;

        rd_addr   = id_reg;
        tab_we    = 1'b0;
        wr_stamp  = stamp_e;
        wr_total  = tot_e;
        wr_count  = cnt_e;
        ord_we    = 1'b0;
        ord_waddr = i_reg[IW-1:0];
        ord_wdata = cur_id_reg;
        ord_raddr = i_reg[IW-1:0];

        if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE: enable_next = cfg_data[0];
                REG_MASK:   mask_next   = cfg_data;
                REG_LIMIT:  limit_next  = cfg_data[15:0];
                default:    ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    unique case (op_t'(in_ch.operation))
                        OP_CLEAR:
                        begin
                            valid_next  = '0;
                            budget_next = limit_reg;
                        end
                        OP_START, OP_STOP:
                        begin
                            // Issue the table read now; update next cycle
                            if (enable_reg && (int'(in_ch.event_id) < NUM_EVENTS))
                            begin
                                op_next    = op_t'(in_ch.operation);
                                id_next    = IW'(in_ch.event_id);
                                ts_next    = STAMP_WIDTH'(in_ch.timestamp);
                                rd_addr    = IW'(in_ch.event_id);
                                state_next = S_UPD;
                            end
                        end
                        OP_REPORT:
                        begin
                            i_next     = '0;
                            sum_next   = '0;
                            nz_next    = '0;
                            state_next = S_SUM_RD;
                        end
                    endcase
                end
            end

            S_UPD:
            begin
                tab_we            = 1'b1;
                valid_next[id_reg] = 1'b1;
                state_next        = S_IDLE;
                if (op_reg == OP_START)
                begin
                    wr_stamp = ts_reg;
                end
                else
                begin
                    wr_total = tot_new;
                    wr_count = cnt_new;
                    if (mask_reg[id6] && (budget_reg != '0))
                    begin
                        budget_next  = budget_reg - 16'd1;
                        trc_el_next  = 48'(elapsed);
                        trc_cnt_next = cnt_new;
                        state_next   = S_TRACE;
                    end
                end
            end

            S_TRACE:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_kind_next = KIND_TRACE;
                    out_id_next   = id6;
                    out_tv_next   = trc_el_reg;
                    out_cnt_next  = trc_cnt_reg;
                    out_sum_next  = '0;
                    out_last_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            // Sum pass: accumulate totals, count live ids, seed the order
            S_SUM_RD:
            begin
                rd_addr    = i_reg[IW-1:0];
                ord_we     = 1'b1;
                ord_waddr  = i_reg[IW-1:0];
                ord_wdata  = i_reg[IW-1:0];
                state_next = S_SUM_ACC;
            end

            S_SUM_ACC:
            begin
                sum_next = rep_sum_sat;
                if (cnt_e != '0)
                begin
                    nz_next = nz_reg + CW'(1);
                end
                if (i_reg == LAST_IDX)
                begin
                    i_next     = '0;
                    state_next = S_SI;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_SUM_RD;
                end
            end

            // Exchange sort: hold the candidate for slot i in cur_*
            S_SI:
            begin
                state_next = S_SI2;
            end

            S_SI2:
            begin
                rd_addr     = ord_q;
                cur_id_next = ord_q;
                state_next  = S_SI3;
            end

            S_SI3:
            begin
                cur_tot_next = tot_e;
                j_next       = i_reg + CW'(1);
                state_next   = (i_reg == LAST_IDX) ? S_SIEND : S_SJ;
            end

            S_SJ:
            begin
                ord_raddr  = j_reg[IW-1:0];
                state_next = S_SJ2;
            end

            S_SJ2:
            begin
                rd_addr    = ord_q;
                jid_next   = ord_q;
                state_next = S_SJ3;
            end

            S_SJ3:
            begin
                if (tot_e > cur_tot_reg)
                begin
                    ord_we       = 1'b1;
                    ord_waddr    = j_reg[IW-1:0];
                    ord_wdata    = cur_id_reg;
                    cur_id_next  = jid_reg;
                    cur_tot_next = tot_e;
                end
                if (j_reg == LAST_IDX)
                begin
                    state_next = S_SIEND;
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_SJ;
                end
            end

            S_SIEND:
            begin
                ord_we = 1'b1;
                if (i_reg == LAST_IDX)
                begin
                    i_next     = '0;
                    n_next     = '0;
                    state_next = (nz_reg == '0) ? S_EMPTY : S_EM;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_SI;
                end
            end

            S_EMPTY:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_kind_next = KIND_EMPTY;
                    out_id_next   = '0;
                    out_tv_next   = '0;
                    out_cnt_next  = '0;
                    out_sum_next  = '0;
                    out_last_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            // Emission: walk the sorted order, skip ids with no stops
            S_EM:
            begin
                state_next = S_EM2;
            end

            S_EM2:
            begin
                rd_addr    = ord_q;
                jid_next   = ord_q;
                state_next = S_EM3;
            end

            S_EM3:
            begin
                rd_addr = jid_reg;
                if (cnt_e == '0)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = (i_reg == LAST_IDX) ? S_IDLE : S_EM;
                end
                else if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_kind_next = KIND_ENTRY;
                    out_id_next   = 6'(jid_reg);
                    out_tv_next   = 48'(tot_e);
                    out_cnt_next  = cnt_e;
                    out_sum_next  = 48'(sum_reg);
                    out_last_next = emit_last;
                    n_next        = n_reg + OUT_CNT_W'(1);
                    i_next        = i_reg + CW'(1);
                    state_next    = (emit_last || (i_reg == LAST_IDX)) ? S_IDLE : S_EM;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ch.ready = (state_reg == S_IDLE);

    assign out_ch.valid        = out_vld_reg;
    assign out_ch.kind         = out_kind_reg;
    assign out_ch.event_id_res = out_id_reg;
    assign out_ch.time_value   = out_tv_reg;
    assign out_ch.event_count  = out_cnt_reg;
    assign out_ch.total_sum    = out_sum_reg;
    assign out_ch.last         = out_last_reg;

endmodule
`default_nettype wire

[rtl/etps_checker.sv]
`default_nettype none
module etps_checker
    import etps_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    etps_in_if.sink    in_ch,
    etps_out_if.source out_ch
);

    // A stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.kind)
            && $stable(out_ch.time_value) && $stable(out_ch.event_id_res))
        else $error("stalled output beat changed");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.kind == KIND_EMPTY) |-> out_ch.last
            && (out_ch.event_count == '0) && (out_ch.total_sum == '0))
        else $error("empty marker malformed");

    a_trace_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.kind == KIND_TRACE) |-> !out_ch.last
            && (out_ch.total_sum == '0))
        else $error("trace record malformed");

    a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && (in_ch.operation == OP_REPORT) |=> !in_ch.ready)
        else $error("input taken during report");

    a_clear_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && (in_ch.operation == OP_CLEAR) |=> in_ch.ready)
        else $error("clear stalled the input");

endmodule

bind event_time_profiler_sorted etps_checker u_etps_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
);
`default_nettype wire
